// File: design/pae_pkg.sv
// Shared constants and types for the proximity alarm beeper.
`timescale 1ns / 1ps
`default_nettype none

package pae_pkg;

  localparam int ADC_BITS   = 12;
  localparam int TIMER_BITS = 16;
  localparam int DIST_W     = 12;
  localparam int CAT_W      = 3;
  localparam int PHASE_W    = 2;
  localparam int GAP_W      = 16;
  localparam int SPEED_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam longint unsigned ADC_FULL    = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned DIV_NUM_VAL = 64'd76800 * ADC_FULL;
  localparam int NUM_W  = $clog2(DIV_NUM_VAL + 64'd1);
  localparam int DEN_W  = ADC_BITS + 10;
  localparam int DSH_W  = DEN_W + DIST_W;
  localparam int CNT_W  = $clog2(DIST_W + 1);

  localparam logic [NUM_W-1:0] DIV_NUM  = NUM_W'(DIV_NUM_VAL);
  localparam logic [DEN_W-1:0] POS_MUL  = DEN_W'(660);
  localparam logic [DEN_W-1:0] DEN_NEG  = DEN_W'(64'd20 * ADC_FULL);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DIST_W);

  localparam int SPEED_SHIFT = 11;
  localparam int FAST_W = (DIST_W + SPEED_SHIFT > SPEED_W + TIMER_BITS) ?
                          DIST_W + SPEED_SHIFT : SPEED_W + TIMER_BITS;

  localparam logic [DIST_W-1:0] DIST_MIN  = DIST_W'(160);
  localparam logic [DIST_W-1:0] DIST_NEAR = DIST_W'(320);
  localparam logic [DIST_W-1:0] DIST_MID  = DIST_W'(480);
  localparam logic [DIST_W-1:0] DIST_FAR  = DIST_W'(800);
  localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(1280);

  localparam logic [CAT_W-1:0] CAT_NONE = 3'd0;
  localparam logic [CAT_W-1:0] CAT_1    = 3'd1;
  localparam logic [CAT_W-1:0] CAT_2    = 3'd2;
  localparam logic [CAT_W-1:0] CAT_3    = 3'd3;
  localparam logic [CAT_W-1:0] CAT_4    = 3'd4;

  localparam logic [PHASE_W-1:0] PH_START = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ON    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_GAP   = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST = 3'd4;

  localparam logic [GAP_W-1:0]   RST_ON   = 16'd9828;
  localparam logic [GAP_W-1:0]   RST_GAP3 = 16'd6553;
  localparam logic [GAP_W-1:0]   RST_GAP2 = 16'd19660;
  localparam logic [GAP_W-1:0]   RST_GAP1 = 16'd32768;
  localparam logic [SPEED_W-1:0] RST_FAST = 8'd10;

  localparam int IN_RAW_W  = ADC_BITS + TIMER_BITS;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 1 + CAT_W + DIST_W + 1;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD   = OUT_W - OUT_RAW_W;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_step;
    logic sample_upd;
    logic tick_upd;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

endpackage

`default_nettype wire

// File: design/pae_ctrl.sv
// Sequencing state machine of the proximity alarm beeper.
`timescale 1ns / 1ps
`default_nettype none

module pae_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_func,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire pae_pkg::stat_t stat,
  output pae_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_INIT = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_SAMPLE   = 3'd3;
  localparam logic [2:0] S_TICK     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (in_func == pae_pkg::FUNC_TICK) ? S_TICK : S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        if (out_free) begin
          cmd.sample_upd = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          cmd.tick_upd = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.sample_upd || cmd.tick_upd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/pae_dp.sv
// Datapath of the proximity alarm beeper: divider, speed test, cadence state.
`timescale 1ns / 1ps
`default_nettype none

module pae_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pae_pkg::cmd_t                       cmd,
  input  wire logic [pae_pkg::ADC_BITS-1:0]        in_adc,
  input  wire logic [pae_pkg::TIMER_BITS-1:0]      in_ts,
  input  wire logic                                cfg_we,
  input  wire logic [pae_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pae_pkg::CFG_DATA_W-1:0]      cfg_data,
  output pae_pkg::stat_t                           stat,
  output logic [pae_pkg::OUT_W-1:0]                out_data
);

  logic [pae_pkg::GAP_W-1:0]   r_on;
  logic [pae_pkg::GAP_W-1:0]   r_gap3;
  logic [pae_pkg::GAP_W-1:0]   r_gap2;
  logic [pae_pkg::GAP_W-1:0]   r_gap1;
  logic [pae_pkg::SPEED_W-1:0] r_fast;

  logic [pae_pkg::ADC_BITS-1:0]   adc_r;
  logic [pae_pkg::TIMER_BITS-1:0] ts_r;

  logic [pae_pkg::DEN_W-1:0] pos;
  logic [pae_pkg::DEN_W-1:0] den;
  logic                      den_ok;
  logic                      den_pos;
  logic [pae_pkg::DSH_W-1:0] dsh;
  logic [pae_pkg::NUM_W-1:0] rem;
  logic [pae_pkg::CNT_W-1:0] cnt;
  logic [pae_pkg::DIST_W-1:0] quo;
  logic                      sat;
  logic                      ge;

  logic [pae_pkg::DIST_W-1:0]     prev_distance;
  logic [pae_pkg::TIMER_BITS-1:0] prev_time;
  logic [pae_pkg::CAT_W-1:0]      current_category;
  logic [pae_pkg::CAT_W-1:0]      last_seen_category;
  logic [pae_pkg::PHASE_W-1:0]    beep_phase;
  logic [pae_pkg::TIMER_BITS-1:0] phase_start_time;
  logic                           buzzer_level;
  logic                           fast_flag;

  logic [pae_pkg::DIST_W-1:0]     dist_calc;
  logic [pae_pkg::TIMER_BITS-1:0] delta;
  logic [pae_pkg::DIST_W:0]       diff;
  logic [pae_pkg::FAST_W-1:0]     lhs;
  logic [pae_pkg::FAST_W-1:0]     rhs;
  logic                           fast_calc;
  logic [pae_pkg::CAT_W-1:0]      cat_calc;

  logic [pae_pkg::TIMER_BITS-1:0] elapsed;
  logic [pae_pkg::PHASE_W-1:0]    ph;
  logic [pae_pkg::PHASE_W-1:0]    beep_phase_next;
  logic [pae_pkg::TIMER_BITS-1:0] phase_start_time_next;
  logic [pae_pkg::CAT_W-1:0]      last_seen_category_next;
  logic                           buzzer_level_next;
  logic [pae_pkg::GAP_W-1:0]      gap_sel;
  logic                           gap_valid;

  assign pos    = pae_pkg::POS_MUL * pae_pkg::DEN_W'(adc_r);
  assign den_ok = pos > pae_pkg::DEN_NEG;
  assign den    = pos - pae_pkg::DEN_NEG;
  assign ge     = {{(pae_pkg::DSH_W - pae_pkg::NUM_W){1'b0}}, rem} >= dsh;
  assign stat.div_last = (cnt == '0);

  always_comb begin
    if (!den_pos) begin
      dist_calc = '0;
    end else if (sat) begin
      dist_calc = '1;
    end else begin
      dist_calc = quo;
    end
  end

  always_comb begin
    delta     = ts_r - prev_time;
    diff      = {1'b0, prev_distance} - {1'b0, dist_calc};
    lhs       = pae_pkg::FAST_W'({diff[pae_pkg::DIST_W-1:0],
                                  {pae_pkg::SPEED_SHIFT{1'b0}}});
    rhs       = pae_pkg::FAST_W'(r_fast) * pae_pkg::FAST_W'(delta);
    fast_calc = (delta != '0) && !diff[pae_pkg::DIST_W] && (lhs > rhs);
    if (dist_calc < pae_pkg::DIST_MIN || dist_calc > pae_pkg::DIST_MAX) begin
      cat_calc = pae_pkg::CAT_NONE;
    end else if (dist_calc <= pae_pkg::DIST_NEAR) begin
      cat_calc = pae_pkg::CAT_4;
    end else if (dist_calc < pae_pkg::DIST_MID) begin
      cat_calc = fast_calc ? pae_pkg::CAT_4 : pae_pkg::CAT_3;
    end else if (dist_calc < pae_pkg::DIST_FAR) begin
      cat_calc = fast_calc ? pae_pkg::CAT_3 : pae_pkg::CAT_2;
    end else begin
      cat_calc = fast_calc ? pae_pkg::CAT_2 : pae_pkg::CAT_1;
    end
  end

  always_comb begin
    case (current_category)
      pae_pkg::CAT_3: begin
        gap_sel   = r_gap3;
        gap_valid = 1'b1;
      end
      pae_pkg::CAT_2: begin
        gap_sel   = r_gap2;
        gap_valid = 1'b1;
      end
      pae_pkg::CAT_1: begin
        gap_sel   = r_gap1;
        gap_valid = 1'b1;
      end
      default: begin
        gap_sel   = r_gap1;
        gap_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    elapsed                 = ts_r - phase_start_time;
    ph                      = beep_phase;
    beep_phase_next         = beep_phase;
    phase_start_time_next   = phase_start_time;
    last_seen_category_next = last_seen_category;
    buzzer_level_next       = buzzer_level;
    if (current_category == pae_pkg::CAT_NONE) begin
      buzzer_level_next = 1'b0;
      beep_phase_next   = pae_pkg::PH_START;
    end else begin
      if (current_category != last_seen_category) begin
        ph                      = pae_pkg::PH_START;
        beep_phase_next         = pae_pkg::PH_START;
        phase_start_time_next   = ts_r;
        last_seen_category_next = current_category;
      end
      case (ph)
        pae_pkg::PH_ON: begin
          if (elapsed >= r_on) begin
            if (current_category == pae_pkg::CAT_4) begin
              beep_phase_next = pae_pkg::PH_START;
            end else begin
              buzzer_level_next     = 1'b0;
              phase_start_time_next = ts_r;
              beep_phase_next       = pae_pkg::PH_GAP;
            end
          end
        end
        pae_pkg::PH_GAP: begin
          if (gap_valid && elapsed >= gap_sel) begin
            beep_phase_next = pae_pkg::PH_START;
          end
        end
        default: begin
          buzzer_level_next     = 1'b1;
          phase_start_time_next = ts_r;
          beep_phase_next       = pae_pkg::PH_ON;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      adc_r <= in_adc;
      ts_r  <= in_ts;
    end
    if (cmd.div_start) begin
      den_pos <= den_ok;
      dsh     <= {den, {pae_pkg::DIST_W{1'b0}}};
      rem     <= pae_pkg::DIV_NUM;
      cnt     <= pae_pkg::CNT_INIT;
      quo     <= '0;
      sat     <= 1'b0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh[pae_pkg::NUM_W-1:0];
      end
      if (cnt == pae_pkg::CNT_INIT) begin
        sat <= ge;
      end else begin
        quo <= {quo[pae_pkg::DIST_W-2:0], ge};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
    if (cmd.sample_upd) begin
      out_data <= {{pae_pkg::OUT_PAD{1'b0}}, fast_calc, dist_calc, cat_calc, buzzer_level};
    end else if (cmd.tick_upd) begin
      out_data <= {{pae_pkg::OUT_PAD{1'b0}}, fast_flag, prev_distance, current_category,
                   buzzer_level_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_on               <= pae_pkg::RST_ON;
      r_gap3             <= pae_pkg::RST_GAP3;
      r_gap2             <= pae_pkg::RST_GAP2;
      r_gap1             <= pae_pkg::RST_GAP1;
      r_fast             <= pae_pkg::RST_FAST;
      prev_distance      <= '0;
      prev_time          <= '0;
      current_category   <= pae_pkg::CAT_NONE;
      last_seen_category <= pae_pkg::CAT_NONE;
      beep_phase         <= pae_pkg::PH_START;
      phase_start_time   <= '0;
      buzzer_level       <= 1'b0;
      fast_flag          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pae_pkg::REG_ON:   r_on   <= cfg_data;
          pae_pkg::REG_GAP3: r_gap3 <= cfg_data;
          pae_pkg::REG_GAP2: r_gap2 <= cfg_data;
          pae_pkg::REG_GAP1: r_gap1 <= cfg_data;
          pae_pkg::REG_FAST: r_fast <= cfg_data[pae_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end
      if (cmd.sample_upd) begin
        prev_distance    <= dist_calc;
        prev_time        <= ts_r;
        fast_flag        <= fast_calc;
        current_category <= cat_calc;
      end
      if (cmd.tick_upd) begin
        beep_phase         <= beep_phase_next;
        phase_start_time   <= phase_start_time_next;
        last_seen_category <= last_seen_category_next;
        buzzer_level       <= buzzer_level_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/proximity_alarm_beeper.sv
// Top level of the proximity alarm beeper.
// Each input transaction yields exactly one output transaction. A tick item
// (tuser 1) runs the beep cadence. A sample item (tuser 0) is latched, then
// the divisor is formed, then the restoring divider takes 13 steps (one
// quotient bit per cycle, the first step detecting saturation at 4095),
// and at last state is updated and the output register loaded. The output
// register holds a result until taken; a new item is accepted once the
// previous one has been loaded there. The configuration channel is always
// ready; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module proximity_alarm_beeper (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [pae_pkg::IN_W-1:0]       s_tdata,   // adc_sample, timestamp
  input  wire logic                           s_tuser,   // func
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [pae_pkg::OUT_W-1:0]           m_tdata,   // buzzer level, category,
                                                         // distance_q4, approaching_fast
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pae_pkg::CFG_DATA_W-1:0] cfg_data
);

  pae_pkg::cmd_t  cmd;
  pae_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  pae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_func   (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pae_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_adc    (s_tdata[pae_pkg::ADC_BITS-1:0]),
    .in_ts     (s_tdata[pae_pkg::IN_RAW_W-1:pae_pkg::ADC_BITS]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the proximity alarm beeper: directed and random stimulus vs a scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import pae_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic              fast;
    logic [DIST_W-1:0] dist_q4;
    logic [CAT_W-1:0]  cat;
    logic              buzz;
  } alarm_out_t;

  class alarm_scoreboard;
    logic [GAP_W-1:0]   on_ticks, gap3, gap2, gap1;
    logic [SPEED_W-1:0] fast_limit;
    logic [DIST_W-1:0]  last_dist;
    logic [15:0]        last_stamp, phase_stamp;
    logic [CAT_W-1:0]   cur_cat, seen_cat;
    logic [PHASE_W-1:0] phase;
    logic               buzzer, fast_seen;
    alarm_out_t         pending_results[$];
    int                 errors;

    function new();
      on_ticks = RST_ON;
      gap3 = RST_GAP3;
      gap2 = RST_GAP2;
      gap1 = RST_GAP1;
      fast_limit = RST_FAST;
      last_dist = '0;
      last_stamp = '0;
      phase_stamp = '0;
      cur_cat = CAT_NONE;
      seen_cat = CAT_NONE;
      phase = PH_START;
      buzzer = 1'b0;
      fast_seen = 1'b0;
      errors = 0;
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ON:   on_ticks = val;
        REG_GAP3: gap3 = val;
        REG_GAP2: gap2 = val;
        REG_GAP1: gap1 = val;
        REG_FAST: fast_limit = val[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function logic [DIST_W-1:0] distance_from_adc(logic [11:0] adc);
      longint unsigned num;
      longint unsigned q;
      num = 64'd660 * adc;
      if (num <= 64'd20 * ADC_FULL) return '0;
      q = (64'd76800 * ADC_FULL) / (num - 64'd20 * ADC_FULL);
      return (q > 64'd4095) ? 12'd4095 : q[DIST_W-1:0];
    endfunction

    function logic [CAT_W-1:0] grade_of(logic [DIST_W-1:0] d, logic fast);
      if (d < DIST_MIN || d > DIST_MAX) return CAT_NONE;
      if (d <= DIST_NEAR) return CAT_4;
      if (d < DIST_MID) return fast ? CAT_4 : CAT_3;
      if (d < DIST_FAR) return fast ? CAT_3 : CAT_2;
      return fast ? CAT_2 : CAT_1;
    endfunction

    function void advance_cadence(logic [15:0] ts);
      logic [15:0] elapsed;
      elapsed = ts - phase_stamp;
      if (cur_cat == CAT_NONE) begin
        buzzer = 1'b0;
        phase = PH_START;
      end else begin
        if (cur_cat != seen_cat) begin
          phase = PH_START;
          phase_stamp = ts;
          seen_cat = cur_cat;
        end
        if (phase == PH_ON) begin
          if (elapsed >= on_ticks) begin
            if (cur_cat == CAT_4) begin
              phase = PH_START;
            end else begin
              buzzer = 1'b0;
              phase_stamp = ts;
              phase = PH_GAP;
            end
          end
        end else if (phase == PH_GAP) begin
          if ((cur_cat == CAT_3 && elapsed >= gap3) ||
              (cur_cat == CAT_2 && elapsed >= gap2) ||
              (cur_cat == CAT_1 && elapsed >= gap1))
            phase = PH_START;
        end else begin
          buzzer = 1'b1;
          phase_stamp = ts;
          phase = PH_ON;
        end
      end
    endfunction

    function void note_item(logic f, logic [11:0] adc, logic [15:0] ts);
      logic [DIST_W-1:0] d;
      logic [15:0]       delta;
      logic              fast;
      int                closing;
      int                allowed;
      alarm_out_t        res;
      if (f == FUNC_SAMPLE) begin
        d = distance_from_adc(adc);
        delta = ts - last_stamp;
        fast = 1'b0;
        if (delta != 0) begin
          closing = int'(last_dist) - int'(d);
          allowed = int'(fast_limit) * int'(delta);
          fast = (closing * 2048 > allowed);
        end
        last_dist = d;
        last_stamp = ts;
        fast_seen = fast;
        cur_cat = grade_of(d, fast);
      end else begin
        advance_cadence(ts);
      end
      res.buzz = buzzer;
      res.cat = cur_cat;
      res.dist_q4 = last_dist;
      res.fast = fast_seen;
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_item(logic [OUT_W-1:0] word);
      alarm_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h with nothing pending", word));
      end else begin
        want = pending_results.pop_front();
        if (word[0] !== want.buzz)
          report($sformatf("buzzer level got %b want %b", word[0], want.buzz));
        if (word[3:1] !== want.cat)
          report($sformatf("category got %0d want %0d", word[3:1], want.cat));
        if (word[15:4] !== want.dist_q4)
          report($sformatf("distance_q4 got %0d want %0d", word[15:4], want.dist_q4));
        if (word[16] !== want.fast)
          report($sformatf("approaching_fast got %b want %b", word[16], want.fast));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  alarm_scoreboard sb;
  int              burst_left = 0;
  int              rx_cycle = 0;
  int              rx_mode = 0;
  logic [15:0]     ts_now = '0;
  logic [11:0]     corner_adc [0:14] = '{12'd0, 12'd124, 12'd125, 12'd240, 12'd496,
                                         12'd497, 12'd719, 12'd720, 12'd1117, 12'd1118,
                                         12'd1613, 12'd1614, 12'd3103, 12'd3104, 12'd4095};

  proximity_alarm_beeper dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (rx_cycle % 7 < 4);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_item(m_tdata);
  end

  function automatic logic [15:0] ts_step(int cap);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'($urandom);
    return 16'($urandom_range(0, cap));
  endfunction

  // Call at a rising edge; returns at the edge that takes the transaction.
  task automatic send_item(input logic f, input logic [11:0] adc, input logic [15:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= IN_W'({ts, adc});
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    sb.note_item(f, adc, ts);
    @(posedge clk);
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.load_register(idx, val);
    @(posedge clk);
  endtask

  // Includes a write to an unmapped index, which must be dropped.
  task automatic set_registers(input logic [15:0] on_t, input logic [15:0] g3,
                               input logic [15:0] g2, input logic [15:0] g1,
                               input logic [15:0] fast_t);
    write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
    write_reg(REG_ON, on_t);
    write_reg(REG_GAP3, g3);
    write_reg(REG_GAP2, g2);
    write_reg(REG_GAP1, g1);
    write_reg(REG_FAST, fast_t);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_items();
    send_item(FUNC_SAMPLE, 12'd0, 16'd0);
    send_item(FUNC_TICK, 12'd0, 16'd5);
    send_item(FUNC_SAMPLE, 12'd4095, 16'd65535);
    send_item(FUNC_SAMPLE, 12'd124, 16'd0);
    send_item(FUNC_SAMPLE, 12'd125, 16'd3);
    send_item(FUNC_SAMPLE, 12'd240, 16'd100);
    send_item(FUNC_SAMPLE, 12'd496, 16'd200);
    send_item(FUNC_SAMPLE, 12'd497, 16'd65000);
    send_item(FUNC_TICK, 12'hFFF, 16'd65100);
    send_item(FUNC_TICK, 12'd0, 16'd9392);
    send_item(FUNC_TICK, 12'd0, 16'd42160);
    send_item(FUNC_TICK, 12'd0, 16'd42161);
    send_item(FUNC_SAMPLE, 12'd719, 16'd42200);
    send_item(FUNC_SAMPLE, 12'd720, 16'd42200);
    send_item(FUNC_SAMPLE, 12'd1117, 16'd50000);
    send_item(FUNC_SAMPLE, 12'd1118, 16'd60000);
    send_item(FUNC_TICK, 12'd0, 16'd60001);
    send_item(FUNC_TICK, 12'd0, 16'd4293);
    send_item(FUNC_TICK, 12'd0, 16'd10846);
    send_item(FUNC_SAMPLE, 12'd1613, 16'd10900);
    send_item(FUNC_SAMPLE, 12'd1614, 16'd10900);
    send_item(FUNC_TICK, 12'd0, 16'd11000);
    send_item(FUNC_TICK, 12'd0, 16'd20828);
    send_item(FUNC_SAMPLE, 12'd3103, 16'd20900);
    send_item(FUNC_SAMPLE, 12'd3104, 16'd21000);
    send_item(FUNC_TICK, 12'd0, 16'd21010);
    ts_now = 16'd21010;
  endtask

  // Repeated samples, each followed by a run of ticks, with occasional out-of-order timestamps.
  task automatic random_run(input int count, input int step_cap);
    int          sent;
    int          pick;
    int          nticks;
    int          nearer;
    logic [11:0] adc;
    logic [11:0] last_adc;
    logic [15:0] ts;
    sent = 0;
    last_adc = 12'd1000;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        adc = 12'($urandom);
      end else if (pick == 1) begin
        adc = corner_adc[$urandom_range(0, 14)];
      end else if (pick < 6) begin
        nearer = int'(last_adc) + $urandom_range(0, 300);
        adc = (nearer > 4095) ? 12'd4095 : 12'(nearer);
      end else begin
        adc = 12'($urandom_range(125, 3200));
      end
      ts_now = ts_now + ts_step(step_cap);
      ts = ($urandom_range(0, 15) == 0) ? 16'($urandom) : ts_now;
      send_item(FUNC_SAMPLE, adc, ts);
      sent++;
      last_adc = adc;
      nticks = $urandom_range(0, 12);
      repeat (nticks) begin
        if (sent < count) begin
          ts_now = ts_now + ts_step(step_cap);
          ts = ($urandom_range(0, 31) == 0) ? 16'($urandom) : ts_now;
          send_item(FUNC_TICK, 12'($urandom), ts);
          sent++;
        end
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    random_run(120, 12000);
    go_idle();

    set_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_run(100, 50);
    go_idle();

    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_run(100, 65535);
    go_idle();

    set_registers(16'($urandom_range(1, 100)), 16'($urandom_range(1, 300)),
                  16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                  16'($urandom));
    random_run(150, 200);
    go_idle();

    set_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    random_run(150, 30000);
    go_idle();

    set_registers(16'($urandom_range(1, 2000)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'd0);
    random_run(130, 3000);
    go_idle();

    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
